### rtl/core/mm2kh_pkg.sv
// ---------------------------------------------------------------------------
// mm2kh_pkg: shared types and constants for the MurmurHash2 key hash core
// Mix constants, register indexes, sequencer state and tail byte mask.
// ---------------------------------------------------------------------------
package mm2kh_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] MIX_MULT   = 32'h5bd1_e995;
  localparam logic [WORD_W-1:0] SEED_RESET = 32'd5381;
  localparam int unsigned MIX_SHIFT   = 24;
  localparam int unsigned FIN_SHIFT_A = 13;
  localparam int unsigned FIN_SHIFT_B = 15;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_SEED   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_MASK = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_K1   = 5'b00010,
    S_K2   = 5'b00100,
    S_HM   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  // byte mask for a short final word of one to three bytes
  function automatic logic [WORD_W-1:0] tail_keep(input logic [1:0] count);
    logic [WORD_W-1:0] keep;
    case (count)
      2'd1:    keep = 32'h0000_00ff;
      2'd2:    keep = 32'h0000_ffff;
      default: keep = 32'h00ff_ffff;
    endcase
    return keep;
  endfunction

endpackage

### rtl/core/mm2kh_if.sv
// ---------------------------------------------------------------------------
// mm2kh_if: channel interfaces for the MurmurHash2 key hash core
// Key word input, hash result output and register write channels.
// ---------------------------------------------------------------------------
interface mm2kh_key_if;
  logic                             valid;
  logic                             ready;
  logic [mm2kh_pkg::WORD_W-1:0]     data_word;
  logic [mm2kh_pkg::COUNT_W-1:0]    valid_bytes;
  logic                             first_word;
  logic                             last_word;
  logic [mm2kh_pkg::WORD_W-1:0]     key_length;

  modport source (output valid, data_word, valid_bytes, first_word, last_word,
                  key_length, input ready);
  modport sink   (input valid, data_word, valid_bytes, first_word, last_word,
                  key_length, output ready);
endinterface

interface mm2kh_result_if;
  logic                         valid;
  logic                         ready;
  logic [mm2kh_pkg::WORD_W-1:0] hash_value;
  logic [mm2kh_pkg::WORD_W-1:0] bucket_index;

  modport source (output valid, hash_value, bucket_index, input ready);
  modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface

interface mm2kh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mm2kh_pkg::CFG_IDX_W-1:0] index;
  logic [mm2kh_pkg::WORD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/murmur2_key_hash_core.sv
// ---------------------------------------------------------------------------
// murmur2_key_hash_core: streaming 32-bit MurmurHash2 with bucket index
// One shared 32x32 multiplier under a five-state sequencer.
// Word steps: full word K1, K2, HM; short word HM; empty word none; a last word
// adds FIN for the avalanche (held while the result register is still occupied).
// The multiplier is the bottleneck: k*M, k*M, h*M, final h*M in turn.
// Reset (rst, sync): seed 5381, mask 0, running hash 0, no result pending.
// ---------------------------------------------------------------------------
module murmur2_key_hash_core (
  input  logic             clk,
  input  logic             rst,
  mm2kh_key_if.sink        key,
  mm2kh_result_if.source   result,
  mm2kh_cfg_if.sink        cfg
);

  mm2kh_pkg::state_t state, state_next;

  logic [mm2kh_pkg::WORD_W-1:0] hash_seed;
  logic [mm2kh_pkg::WORD_W-1:0] bucket_mask;
  logic [mm2kh_pkg::WORD_W-1:0] running_hash;
  logic [mm2kh_pkg::WORD_W-1:0] block;
  logic                         last;
  logic                         out_valid;
  logic [mm2kh_pkg::WORD_W-1:0] out_hash;
  logic [mm2kh_pkg::WORD_W-1:0] out_bucket;

  logic                         key_take;
  logic                         out_free;
  logic                         is_full;
  logic                         is_empty;
  logic [mm2kh_pkg::WORD_W-1:0] start_hash;
  logic [mm2kh_pkg::WORD_W-1:0] mul_a;
  logic [mm2kh_pkg::WORD_W-1:0] mul_p;
  logic [mm2kh_pkg::WORD_W-1:0] fin_hash;

  assign key.ready    = (state == mm2kh_pkg::S_IDLE);
  assign key_take     = key.valid && key.ready;
  assign out_free     = !out_valid || result.ready;
  assign cfg.ready    = 1'b1;

  assign result.valid        = out_valid;
  assign result.hash_value   = out_hash;
  assign result.bucket_index = out_bucket;

  assign is_full    = (key.valid_bytes >= mm2kh_pkg::FULL_COUNT);
  assign is_empty   = (key.valid_bytes == '0);
  assign start_hash = key.first_word ? (hash_seed ^ key.key_length) : running_hash;

  // shared multiplier, product truncated to 32 bits
  always_comb begin
    case (state)
      mm2kh_pkg::S_K1,
      mm2kh_pkg::S_K2: mul_a = block;
      mm2kh_pkg::S_HM: mul_a = running_hash;
      default:         mul_a = running_hash ^ (running_hash >> mm2kh_pkg::FIN_SHIFT_A);
    endcase
  end

  assign mul_p    = mul_a * mm2kh_pkg::MIX_MULT;
  assign fin_hash = mul_p ^ (mul_p >> mm2kh_pkg::FIN_SHIFT_B);

  always_comb begin
    state_next = state;
    case (state)
      mm2kh_pkg::S_IDLE: begin
        if (key_take) begin
          if (is_full) begin
            state_next = mm2kh_pkg::S_K1;
          end else if (!is_empty) begin
            state_next = mm2kh_pkg::S_HM;
          end else if (key.last_word) begin
            state_next = mm2kh_pkg::S_FIN;
          end
        end
      end
      mm2kh_pkg::S_K1: state_next = mm2kh_pkg::S_K2;
      mm2kh_pkg::S_K2: state_next = mm2kh_pkg::S_HM;
      mm2kh_pkg::S_HM: state_next = last ? mm2kh_pkg::S_FIN : mm2kh_pkg::S_IDLE;
      mm2kh_pkg::S_FIN: begin
        if (out_free) begin
          state_next = mm2kh_pkg::S_IDLE;
        end
      end
      default: state_next = mm2kh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mm2kh_pkg::S_IDLE;
      running_hash <= '0;
      hash_seed    <= mm2kh_pkg::SEED_RESET;
      bucket_mask  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          mm2kh_pkg::REG_HASH_SEED:   hash_seed   <= cfg.data;
          mm2kh_pkg::REG_BUCKET_MASK: bucket_mask <= cfg.data;
          default: ;
        endcase
      end

      if (state == mm2kh_pkg::S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        mm2kh_pkg::S_IDLE: begin
          if (key_take) begin
            last <= key.last_word;
            if (is_full) begin
              running_hash <= start_hash;
              block        <= key.data_word;
            end else if (!is_empty) begin
              // tail fold: xor bytes in, then h*M ^ 0 in the mix step
              running_hash <= start_hash
                              ^ (key.data_word & mm2kh_pkg::tail_keep(key.valid_bytes[1:0]));
              block        <= '0;
            end else begin
              running_hash <= start_hash;
            end
          end
        end
        mm2kh_pkg::S_K1: block <= mul_p ^ (mul_p >> mm2kh_pkg::MIX_SHIFT);
        mm2kh_pkg::S_K2: block <= mul_p;
        mm2kh_pkg::S_HM: running_hash <= mul_p ^ block;
        mm2kh_pkg::S_FIN: begin
          if (out_free) begin
            out_hash   <= fin_hash;
            out_bucket <= fin_hash & bucket_mask;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_full_word_mixes: assert property (@(posedge clk) disable iff (rst)
    (key.valid && key.ready && key.valid_bytes >= mm2kh_pkg::FULL_COUNT)
      |=> state == mm2kh_pkg::S_K1)
    else $error("full word did not start block mix");

  a_fin_emits: assert property (@(posedge clk) disable iff (rst)
    (state == mm2kh_pkg::S_FIN && (!result.valid || result.ready))
      |=> (result.valid && state == mm2kh_pkg::S_IDLE))
    else $error("avalanche did not produce a result word");

  a_mid_word_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == mm2kh_pkg::S_HM && !last) |=> (state == mm2kh_pkg::S_IDLE && !$rose(result.valid)))
    else $error("non-last word produced a result");
`endif

endmodule
